// File: sv/npcm_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// npcm_pkg
// shared types, constants and helpers for the nearest palette color match
// ---------------------------------------------------------------------------
package npcm_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int COLOR_W         = 8;
   localparam int INDEX_W         = 8;
   localparam int DIST_W          = 10;

   localparam logic [COLOR_W-1:0] RESET_THRESHOLD   = 8'd220;
   localparam logic [INDEX_W-1:0] TRANSPARENT_INDEX = 8'd255;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_MATCH = 1'b1;

   typedef struct packed {
      logic               func;
      logic [INDEX_W-1:0] entry_index;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } req_type;

   typedef struct packed {
      logic [INDEX_W-1:0] color_index;
      logic               transparent;
   } rsp_type;

   // palette write broadcast to every cell
   typedef struct packed {
      logic               en;
      logic [INDEX_W-1:0] index;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
   } pal_wr_type;

   // search token handed from cell to cell
   typedef struct packed {
      logic               valid;
      logic [COLOR_W-1:0] red;
      logic [COLOR_W-1:0] green;
      logic [COLOR_W-1:0] blue;
      logic [DIST_W-1:0]  best_dist;
      logic [INDEX_W-1:0] best_idx;
   } token_type;

   function automatic logic [COLOR_W-1:0] abs_diff(input logic [COLOR_W-1:0] a,
                                                   input logic [COLOR_W-1:0] b);
      return (a > b) ? (a - b) : (b - a);
   endfunction

endpackage : npcm_pkg
`default_nettype wire

// File: sv/nearest_palette_color_match_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// nearest_palette_color_match_core
// palette lookup by least manhattan distance over a chain of entry cells
// ---------------------------------------------------------------------------
// usage
//   req channel (valid/ready): one beat per item. func write stores red, green
//   and blue at entry_index and gives no response; indexes past the palette
//   are dropped. func match gives exactly one rsp beat.
//   csr port: csr_wr_en/csr_wr_data load the transparency threshold at once.
//   a match whose three channels all exceed the threshold answers index 255
//   with the transparent flag in the cycle after acceptance.
//   any other match sends a token down PALETTE_ENTRIES cells, one cell per
//   cycle, and the response is registered once the token leaves the last
//   cell. the chain carries a single token; one write or transparent match
//   per cycle while req_ready is high. req_ready drops while a token is in
//   the chain and while a response sits in the output register with
//   rsp_ready low.
//   reset: all palette entries go to zero, threshold to 220, nothing in flight.
//   a stalled rsp beat holds its payload until rsp_ready.
// ---------------------------------------------------------------------------
module nearest_palette_color_match_core
   import npcm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire req_type            req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output rsp_type                 rsp_data,
   input  wire logic               csr_wr_en,
   input  wire logic [COLOR_W-1:0] csr_wr_data
);

   logic [COLOR_W-1:0]         thresh_ff;
   logic                       busy_ff, busy_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   rsp_type                    rsp_ff, rsp_in;
   logic                       req_fire, is_match, is_clear;
   pal_wr_type                 pal_wr;
   token_type                  chain [PALETTE_ENTRIES+1];
   logic [PALETTE_ENTRIES-1:0] chain_vld;
   token_type                  tail;

   // threshold register
   always_ff @(posedge clock) begin
      if (reset) begin
         thresh_ff <= RESET_THRESHOLD;
      end else if (csr_wr_en) begin
         thresh_ff <= csr_wr_data;
      end
   end

   // take a beat only with the chain empty and room in the output stage
   assign req_ready = !busy_ff && (!rsp_valid_ff || rsp_ready);
   assign req_fire  = req_valid && req_ready;
   assign is_match  = (req_data.func == FUNC_MATCH);
   assign is_clear  = (req_data.red > thresh_ff) && (req_data.green > thresh_ff)
                   && (req_data.blue > thresh_ff);

   // palette write broadcast
   assign pal_wr.en    = req_fire && (req_data.func == FUNC_WRITE);
   assign pal_wr.index = req_data.entry_index;
   assign pal_wr.red   = req_data.red;
   assign pal_wr.green = req_data.green;
   assign pal_wr.blue  = req_data.blue;

   // token launch, best distance starts above any real distance
   always_comb begin
      chain[0].valid     = req_fire && is_match && !is_clear;
      chain[0].red       = req_data.red;
      chain[0].green     = req_data.green;
      chain[0].blue      = req_data.blue;
      chain[0].best_dist = '1;
      chain[0].best_idx  = '0;
   end

   // the cell row, entry i lives in cell i
   for (genvar i = 0; i < PALETTE_ENTRIES; i++) begin : g_cell
      npcm_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (INDEX_W'(i)),
         .pal_wr     (pal_wr),
         .tok_in     (chain[i]),
         .tok_out    (chain[i+1])
      );
      assign chain_vld[i] = chain[i+1].valid;
   end

   assign tail = chain[PALETTE_ENTRIES];

   // chain occupancy
   always_comb begin
      busy_in = busy_ff;
      if (chain[0].valid) begin
         busy_in = 1'b1;
      end else if (tail.valid) begin
         busy_in = 1'b0;
      end
   end

   // output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (tail.valid) begin
         rsp_valid_in       = 1'b1;
         rsp_in.color_index = tail.best_idx;
         rsp_in.transparent = 1'b0;
      end else if (req_fire && is_match && is_clear) begin
         rsp_valid_in       = 1'b1;
         rsp_in.color_index = TRANSPARENT_INDEX;
         rsp_in.transparent = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // at most one token anywhere in the chain
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $onehot0(chain_vld))
      else $error("more than one search token in the chain");

   // a finished search never lands on a pending response
   a_tail_room: assert property (@(posedge clock) disable iff (reset)
      tail.valid |-> !rsp_valid_ff)
      else $error("search result would overwrite a pending response");

   // a token in the chain is only there while busy
   a_busy_track: assert property (@(posedge clock) disable iff (reset)
      (chain_vld != '0) |-> busy_ff)
      else $error("token in chain while not busy");

   // transparent match answers on the next cycle
   a_clear_rsp: assert property (@(posedge clock) disable iff (reset)
      (req_fire && is_match && is_clear) |=> (rsp_valid_ff && rsp_ff.transparent
                                             && (rsp_ff.color_index == TRANSPARENT_INDEX)))
      else $error("transparent match did not answer at once");

   // a searched match starts a scan
   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      chain[0].valid |=> (busy_ff && !req_ready))
      else $error("scan launched without blocking the request side");

endmodule : nearest_palette_color_match_core
`default_nettype wire

// File: sv/npcm_cell.sv
`default_nettype none
// ---------------------------------------------------------------------------
// npcm_cell
// one palette entry plus one stage of the search chain
// ---------------------------------------------------------------------------
module npcm_cell
   import npcm_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic [INDEX_W-1:0] cell_index,
   input  wire pal_wr_type         pal_wr,
   input  wire token_type          tok_in,
   output token_type               tok_out
);

   logic [COLOR_W-1:0] entry_r_ff, entry_g_ff, entry_b_ff;
   token_type          tok_ff, tok_in_next;
   logic [DIST_W-1:0]  entry_gap;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_r_ff <= '0;
         entry_g_ff <= '0;
         entry_b_ff <= '0;
      end else if (pal_wr.en && (pal_wr.index == cell_index)) begin
         entry_r_ff <= pal_wr.red;
         entry_g_ff <= pal_wr.green;
         entry_b_ff <= pal_wr.blue;
      end
   end

   // manhattan distance to this entry
   assign entry_gap = DIST_W'(abs_diff(tok_in.red, entry_r_ff))
                    + DIST_W'(abs_diff(tok_in.green, entry_g_ff))
                    + DIST_W'(abs_diff(tok_in.blue, entry_b_ff));

   always_comb begin
      tok_in_next = tok_in;
      // strict less keeps the lower index on a tie
      if (entry_gap < tok_in.best_dist) begin
         tok_in_next.best_dist = entry_gap;
         tok_in_next.best_idx  = cell_index;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff.valid <= 1'b0;
      end else begin
         tok_ff.valid <= tok_in.valid;
      end
      tok_ff.red       <= tok_in_next.red;
      tok_ff.green     <= tok_in_next.green;
      tok_ff.blue      <= tok_in_next.blue;
      tok_ff.best_dist <= tok_in_next.best_dist;
      tok_ff.best_idx  <= tok_in_next.best_idx;
   end

   assign tok_out = tok_ff;

endmodule : npcm_cell
`default_nettype wire
